// File: rtl/sml_pkg.sv
// ----------------------------------------------------------------------------
// sml_pkg: shared definitions for the sorted magnitude list
// Operation and status codes, field widths and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sml_pkg;

  localparam int ENTRY_W  = 32;
  localparam int MAG_W    = 33;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                load;
    logic                st_we;
    logic [STATUS_W-1:0] st_val;
    logic                found_clr;
    logic                found_set;
    logic                idx_clr;
    logic                idx_ld_cnt;
    logic                idx_inc;
    logic                idx_dec;
    logic                rd_en;
    logic                rd_prev;
    logic                wr_en;
    logic                wr_val;
    logic                wr_prev;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                out_ld;
  } sml_cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_end;
    logic greater;
    logic equal;
    logic found;
    logic out_last;
  } sml_sts_t;

endpackage

// File: rtl/sml_dpath.sv
// ----------------------------------------------------------------------------
// sml_dpath: list storage and datapath
// Holds the list memory, entry count, scan index, operand, status and the
// output register; carries out the commands issued by the controller.
// ----------------------------------------------------------------------------
module sml_dpath
  import sml_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sml_cmd_t            cmd,
  output sml_sts_t            sts,
  input  logic                in_op,
  input  logic [ENTRY_W-1:0]  in_value,
  output logic [ENTRY_W-1:0]  out_entry,
  output logic                out_entry_valid,
  output logic                out_last,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [MAG_W-1:0] mag33(input logic [ENTRY_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[ENTRY_W-1], v};
    return v[ENTRY_W-1] ? (~ext + MAG_W'(1)) : ext;
  endfunction

  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata_r;
  logic                op_r;
  logic [ENTRY_W-1:0]  val_r;
  logic [MAG_W-1:0]    mag_r;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       idx_r;
  logic                found_r;
  logic [STATUS_W-1:0] status_r;
  logic [ENTRY_W-1:0]  oentry_r;
  logic                ovalid_r;
  logic                olast_r;

  logic [CW-1:0]       idx_prev;
  logic [CW-1:0]       rd_addr;
  logic [CW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                idx_end;

  assign idx_prev = idx_r - CW'(1);
  assign rd_addr  = cmd.rd_prev ? idx_prev : idx_r;
  assign wr_addr  = cmd.wr_prev ? idx_prev : idx_r;
  assign wr_data  = cmd.wr_val ? val_r : rdata_r;
  assign idx_end  = ({1'b0, idx_r} + (CW + 1)'(1)) == {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      val_r <= in_value;
      mag_r <= mag33(in_value);
    end
    if (cmd.st_we) begin
      status_r <= cmd.st_val;
    end
    if (cmd.out_ld) begin
      if (cnt_r == '0) begin
        oentry_r <= '0;
        ovalid_r <= 1'b0;
        olast_r  <= 1'b1;
      end else begin
        oentry_r <= rdata_r;
        ovalid_r <= 1'b1;
        olast_r  <= idx_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_ld_cnt) begin
        idx_r <= cnt_r;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end else if (cmd.idx_dec) begin
        idx_r <= idx_prev;
      end
      if (cmd.found_clr) begin
        found_r <= 1'b0;
      end else if (cmd.found_set) begin
        found_r <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.full     = (cnt_r == CW'(DEPTH));
    sts.empty    = (cnt_r == '0);
    sts.idx_zero = (idx_r == '0);
    sts.idx_end  = idx_end;
    sts.greater  = (mag33(rdata_r) > mag_r);
    sts.equal    = (rdata_r == val_r);
    sts.found    = found_r;
    sts.out_last = olast_r;
  end

  assign out_entry       = oentry_r;
  assign out_entry_valid = ovalid_r;
  assign out_last        = olast_r;
  assign out_status      = status_r;
  assign out_count       = COUNT_W'(cnt_r);

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (wr_addr < CW'(DEPTH)))
    else $error("list write beyond depth");

  a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("entry count grows past depth");

  a_no_shrink_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.empty)
    else $error("entry count drops below zero");

endmodule

// File: rtl/sml_ctrl.sv
// ----------------------------------------------------------------------------
// sml_ctrl: operation sequencer
// Accepts one item, steps the datapath through the insert or delete scan,
// then walks the list and presents one result per entry, or one if it is empty.
// ----------------------------------------------------------------------------
module sml_ctrl
  import sml_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output sml_cmd_t cmd,
  input  sml_sts_t sts
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DISP    = 9'b000000010,
    S_INS_RD  = 9'b000000100,
    S_INS_EV  = 9'b000001000,
    S_DEL_RD  = 9'b000010000,
    S_DEL_EV  = 9'b000100000,
    S_DEL_FIN = 9'b001000000,
    S_EMIT_RD = 9'b010000000,
    S_OUT     = 9'b100000000
  } sml_state_t;

  sml_state_t state_r, state_nxt;
  logic       emit_ld_r, emit_ld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      emit_ld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      emit_ld_r <= emit_ld_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt   = state_r;
    emit_ld_nxt = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.st_we = 1'b1;
        if (sts.op == OP_INSERT) begin
          if (sts.full) begin
            cmd.st_val  = ST_FULL;
            cmd.idx_clr = 1'b1;
            state_nxt   = S_EMIT_RD;
          end else begin
            cmd.st_val     = ST_OK;
            cmd.idx_ld_cnt = 1'b1;
            state_nxt      = S_INS_RD;
          end
        end else begin
          cmd.idx_clr = 1'b1;
          if (sts.empty) begin
            cmd.st_val = ST_EMPTY;
            state_nxt  = S_EMIT_RD;
          end else begin
            cmd.st_val    = ST_NOT_FOUND;
            cmd.found_clr = 1'b1;
            state_nxt     = S_DEL_RD;
          end
        end
      end
      S_INS_RD: begin
        if (sts.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_EMIT_RD;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_EV;
        end
      end
      S_INS_EV: begin
        cmd.wr_en = 1'b1;
        if (sts.greater) begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_INS_RD;
        end else begin
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_EMIT_RD;
        end
      end
      S_DEL_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DEL_EV;
      end
      S_DEL_EV: begin
        if (sts.found) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_prev = 1'b1;
        end else if (sts.equal) begin
          cmd.found_set = 1'b1;
        end
        if (sts.idx_end) begin
          state_nxt = S_DEL_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DEL_RD;
        end
      end
      S_DEL_FIN: begin
        cmd.idx_clr = 1'b1;
        if (sts.found) begin
          cmd.cnt_dec = 1'b1;
          cmd.st_we   = 1'b1;
          cmd.st_val  = ST_OK;
        end
        state_nxt = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        if (emit_ld_r || sts.empty) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.rd_en   = 1'b1;
          emit_ld_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken before the first is done");

  a_emit_reads_once: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ld_r |-> (state_r == S_EMIT_RD))
    else $error("list read pending outside of emit");

endmodule

// File: rtl/sorted_magnitude_list.sv
// ----------------------------------------------------------------------------
// sorted_magnitude_list: bounded list ordered by ascending magnitude
// Inserts or deletes one signed value per item and then emits the whole list.
// ----------------------------------------------------------------------------
// One item is processed at a time. An insert walks the list from its tail
// toward the insertion point and a delete walks it from the head to the tail,
// visiting each entry through a single registered read of the list memory.
// The list is then emitted one result per entry: each entry is read, loaded
// into the output register and held there while out_stall is high, or one
// result is emitted for an empty list. status and count are the same on
// every result of an item; last marks its final result, and entry_valid is
// low only on the single result that reports an empty list. The memory needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_magnitude_list
  import sml_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic signed [ENTRY_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [ENTRY_W-1:0]  out_entry,
  output logic                       out_entry_valid,
  output logic                       out_last,
  output logic        [STATUS_W-1:0] out_status,
  output logic        [COUNT_W-1:0]  out_count
);

  sml_cmd_t           cmd;
  sml_sts_t           sts;
  logic [ENTRY_W-1:0] entry;

  sml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sml_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_entry       (entry),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last),
    .out_status      (out_status),
    .out_count       (out_count)
  );

  assign out_entry = entry;

endmodule
